// ----- rtl/text_console_char_writer_core_defines.svh -----
// Assertion macros used by the back part of the text console character writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tccw_pkg.sv -----
// Package with the types and constants of the text console character writer.
`default_nettype none

package tccw_pkg;

  localparam int CELL_INDEX_W = 11;
  // Cell address width of a queue entry (up to 32768 cells).
  localparam int QADDR_W = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // One classified item travelling from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [QADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [6:0]        cursor_column;
    logic [4:0]        cursor_row;
    logic              screen_cleared;
  } queue_entry_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/tccw_front.sv -----
// Front part: accepts items, tracks the cursor and classifies each item.
`default_nettype none

module tccw_front
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    command,
  input  wire logic [7:0]              character,
  input  wire logic [CELL_INDEX_W-1:0] cell_index,
  input  wire back_status_t            status,
  input  wire logic                    q_full,
  output logic                         q_push,
  output queue_entry_t                 q_push_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] row_base_next;
  logic              accept;
  logic              row_advance;
  logic              clear;

  assign in_ready = !q_full && !status.init_busy;
  assign accept = in_valid && in_ready;
  assign q_push = accept;

  always_comb begin
    col_next = col;
    row_next = row;
    row_base_next = row_base;
    row_advance = 1'b0;
    clear = 1'b0;
    q_push_data = '0;
    q_push_data.op = OP_NONE;
    if (command) begin
      if (int'(cell_index) < CELL_COUNT) begin
        q_push_data.op = OP_READ;
        q_push_data.addr = QADDR_W'(cell_index);
      end
    end else begin
      if (character == NEWLINE_CHAR) begin
        row_advance = 1'b1;
      end else begin
        q_push_data.op = OP_WRITE;
        q_push_data.addr = QADDR_W'(row_base + ADDR_W'(col));
        q_push_data.data = character;
        if (col == COL_W'(COLUMNS - 1)) begin
          row_advance = 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      if (row_advance) begin
        col_next = '0;
        if (row == ROW_W'(ROWS - 1)) begin
          clear = 1'b1;
          row_next = '0;
          row_base_next = '0;
        end else begin
          row_next = row + 1'b1;
          row_base_next = row_base + ADDR_W'(COLUMNS);
        end
      end
    end
    // A put that blanks the screen needs no write of its own.
    if (clear) begin
      q_push_data.op = OP_CLEAR;
    end
    q_push_data.cursor_column = 7'(col_next);
    q_push_data.cursor_row = 5'(row_next);
    q_push_data.screen_cleared = clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      row_base <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      row_base <= row_base_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tccw_queue.sv -----
// Short queue of classified items between the front and the back.
`default_nettype none

module tccw_queue
  import tccw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire queue_entry_t push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output queue_entry_t      data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign data = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tccw_back.sv -----
// Back part: owns the character plane, performs reads, writes and clears.
`default_nettype none
`include "text_console_char_writer_core_defines.svh"

module tccw_back
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire queue_entry_t q_data,
  output logic              q_pop,
  output back_status_t      status,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [6:0]        cursor_column,
  output logic [4:0]        cursor_row,
  output logic              screen_cleared,
  output logic [7:0]        cell_char
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_INIT  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_last;
  logic [7:0]        screen [CELL_COUNT];
  logic [7:0]        rdata;
  logic              rsp_valid;
  logic              rsp_is_read;
  logic [ADDR_W-1:0] entry_addr;

  assign entry_addr = q_data.addr[ADDR_W-1:0];
  assign sweep_last = (sweep_addr == ADDR_W'(CELL_COUNT - 1));
  assign q_pop = q_valid && (state == ST_RUN) && (!rsp_valid || out_ready);
  assign status.init_busy = (state == ST_INIT);

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (q_pop && q_data.op == OP_CLEAR) begin
          state_next = ST_CLEAR;
        end
      end
      ST_INIT, ST_CLEAR: begin
        if (sweep_last) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != ST_RUN) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (q_pop) begin
        rsp_valid <= 1'b1;
      end else if (out_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The sweep owns the write port; items wait in the queue meanwhile.
  always_ff @(posedge clk) begin
    if (state != ST_RUN) begin
      screen[sweep_addr] <= SPACE_CHAR;
    end else if (q_pop && q_data.op == OP_WRITE) begin
      screen[entry_addr] <= q_data.data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.op == OP_READ) begin
      rdata <= screen[entry_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp_is_read <= (q_data.op == OP_READ);
      cursor_column <= q_data.cursor_column;
      cursor_row <= q_data.cursor_row;
      screen_cleared <= q_data.screen_cleared;
    end
  end

  assign out_valid = rsp_valid;
  assign cell_char = rsp_is_read ? rdata : 8'h00;

  `TCCW_ASSERT_SAME(a_no_pop_in_sweep, clk, rst, state != ST_RUN, !q_pop,
                    "item taken from the queue while the screen is being blanked")
  `TCCW_ASSERT_NEXT(a_clear_starts_sweep, clk, rst, q_pop && q_data.op == OP_CLEAR,
                    state == ST_CLEAR, "clear item did not start the blanking sweep")
  `TCCW_ASSERT_SAME(a_sweep_idle_at_home, clk, rst, state == ST_RUN, sweep_addr == '0,
                    "sweep address left away from zero outside a sweep")
  `TCCW_ASSERT_SAME(a_no_overwrite_pending, clk, rst, rsp_valid && !out_ready, !q_pop,
                    "pending result overwritten before its transfer")

endmodule

`default_nettype wire

// ----- rtl/text_console_char_writer_core.sv -----
// Text console character writer: an 80 x 25 character plane with a cursor.
//
// Input channel (in_valid / in_ready) carries command, character and
// cell_index. A put stores the character at the cursor and advances it; a
// newline moves to column 0 of the next row; passing the last row blanks the
// screen and homes the cursor. A read returns the stored byte of one cell.
// Output channel (out_valid / out_ready) returns one result per item, in
// order: cursor position after the item, the cleared flag and the read byte.
// Each item passes through the queue and then the output register before
// out_valid rises. Puts and reads sustain one item per cycle while the
// receiver keeps out_ready high and no sweep runs. A put that blanks the
// screen starts a sweep over all COLUMNS * ROWS cells that writes spaces,
// one cell per cycle, and later items wait in the queue until it ends.
// After reset the same sweep runs once with in_ready low until it ends.
// When the receiver stalls, the result holds in the output register and the
// four-entry queue keeps taking items until it fills, then in_ready drops.
`default_nettype none

module text_console_char_writer_core
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    command,
  input  wire logic [7:0]              character,
  input  wire logic [CELL_INDEX_W-1:0] cell_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [6:0]                   cursor_column,
  output logic [4:0]                   cursor_row,
  output logic                         screen_cleared,
  output logic [7:0]                   cell_char
);

  back_status_t status;
  queue_entry_t push_data;
  queue_entry_t pop_data;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;

  tccw_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .character(character),
    .cell_index(cell_index),
    .status(status),
    .q_full(q_full),
    .q_push(q_push),
    .q_push_data(push_data)
  );

  tccw_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(push_data),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .data(pop_data)
  );

  tccw_back #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(pop_data),
    .q_pop(q_pop),
    .status(status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_column(cursor_column),
    .cursor_row(cursor_row),
    .screen_cleared(screen_cleared),
    .cell_char(cell_char)
  );

endmodule

`default_nettype wire

// ----- tb/text_console_char_writer_core_tb.sv -----
// Testbench for the text console character writer: directed and random traffic checked against a screen model.
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;
  import tccw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       screen_cleared;
    logic [7:0] cell_char;
  } console_result_t;

  // Tracks the screen and cursor and queues the result each accepted command should give.
  class console_screen_scoreboard;
    logic [7:0] screen [CELL_COUNT];
    int unsigned col_pos;
    int unsigned row_pos;
    console_result_t expected_cursor_results [$];
    int unsigned failures;

    function new();
      blank_screen();
      col_pos = 0;
      row_pos = 0;
      failures = 0;
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = SPACE_CHAR;
    endfunction

    function int unsigned pending();
      return expected_cursor_results.size();
    endfunction

    function void note_accepted_item(logic cmd, logic [7:0] ch, logic [CELL_INDEX_W-1:0] idx);
      console_result_t want;
      int unsigned pos;
      want = '0;
      if (cmd == CMD_READ) begin
        if (idx < CELL_COUNT) want.cell_char = screen[idx];
      end else begin
        if (ch == NEWLINE_CHAR) begin
          col_pos = 0;
          row_pos++;
        end else begin
          pos = row_pos * COLUMNS + col_pos;
          if (pos < CELL_COUNT) screen[pos] = ch;
          col_pos++;
        end
        if (col_pos >= COLUMNS) begin
          col_pos = 0;
          row_pos++;
        end
        // Running off the last row blanks the whole plane and homes the cursor.
        if (row_pos >= ROWS) begin
          blank_screen();
          col_pos = 0;
          row_pos = 0;
          want.screen_cleared = 1'b1;
        end
      end
      want.cursor_column = col_pos[6:0];
      want.cursor_row = row_pos[4:0];
      expected_cursor_results.push_back(want);
    endfunction

    function void report_mismatch(string what, console_result_t want, console_result_t got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s: expected col %0d row %0d clr %0b chr %02h,",
                 $time, what, want.cursor_column, want.cursor_row, want.screen_cleared,
                 want.cell_char, " got col %0d row %0d clr %0b chr %02h",
                 got.cursor_column, got.cursor_row, got.screen_cleared, got.cell_char);
    endfunction

    function void check_cursor_result(console_result_t got);
      console_result_t want;
      if (expected_cursor_results.size() == 0) begin
        report_mismatch("result with no pending transfer", '0, got);
        return;
      end
      want = expected_cursor_results.pop_front();
      if (got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row ||
          got.screen_cleared !== want.screen_cleared || got.cell_char !== want.cell_char)
        report_mismatch("result mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_PUT;
  logic [7:0] character = 8'h00;
  logic [CELL_INDEX_W-1:0] cell_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [6:0] cursor_column;
  logic [4:0] cursor_row;
  logic screen_cleared;
  logic [7:0] cell_char;

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 57;
  int unsigned cycle_count = 0;

  console_screen_scoreboard screen_board = new();

  text_console_char_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .character(character),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_column(cursor_column),
    .cursor_row(cursor_row),
    .screen_cleared(screen_cleared),
    .cell_char(cell_char)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) screen_board.note_accepted_item(command, character, cell_index);
      if (out_valid && out_ready)
        screen_board.check_cursor_result({cursor_column, cursor_row, screen_cleared, cell_char});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drives one command and returns at the edge where its transfer happens.
  task automatic send_item(input logic cmd, input logic [7:0] ch,
                           input logic [CELL_INDEX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    command <= cmd;
    character <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (screen_board.pending() != 0) @(posedge clk);
  endtask

  // Bursts of newlines, text lines and reads so that the cursor wraps and the screen clears often.
  task automatic run_random_bursts(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    int unsigned pos;
    int unsigned back;
    logic [7:0] ch;
    logic [CELL_INDEX_W-1:0] idx;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) send_item(CMD_PUT, NEWLINE_CHAR, CELL_INDEX_W'($urandom));
      end else if (pick < 70 || pick >= 95) begin
        run_len = (pick >= 95) ? $urandom_range(80, 170) : $urandom_range(1, 40);
        repeat (run_len) begin
          if ($urandom_range(11) == 0) ch = NEWLINE_CHAR;
          else if ($urandom_range(7) == 0) ch = 8'($urandom_range(255));
          else ch = 8'($urandom_range(32, 126));
          send_item(CMD_PUT, ch, CELL_INDEX_W'($urandom));
        end
      end else begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          pos = screen_board.row_pos * COLUMNS + screen_board.col_pos;
          pick = $urandom_range(9);
          if (pick < 5) begin
            // Look back at cells that were written recently.
            back = (pos < 40) ? pos : 40;
            idx = (back == 0) ? '0 : CELL_INDEX_W'(pos - $urandom_range(1, back));
          end else if (pick < 8) begin
            idx = CELL_INDEX_W'($urandom_range(CELL_COUNT - 1));
          end else if (pick < 9) begin
            idx = CELL_INDEX_W'($urandom_range(CELL_COUNT, 2 ** CELL_INDEX_W - 1));
          end else begin
            idx = CELL_INDEX_W'($urandom);
          end
          send_item(CMD_READ, 8'($urandom), idx);
        end
      end
      sent += run_len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: untouched cells, out-of-range reads, extreme bytes, newline.
    send_item(CMD_READ, 8'hFF, 11'd0);
    send_item(CMD_READ, 8'h00, CELL_INDEX_W'(CELL_COUNT - 1));
    send_item(CMD_READ, 8'h00, CELL_INDEX_W'(CELL_COUNT));
    send_item(CMD_READ, 8'hFF, 11'h7FF);
    send_item(CMD_PUT, 8'h00, 11'h7FF);
    send_item(CMD_PUT, 8'hFF, 11'd0);
    send_item(CMD_PUT, 8'h41, 11'd5);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd1);
    send_item(CMD_READ, 8'h00, 11'd2);
    send_item(CMD_READ, 8'h00, 11'd3);
    send_item(CMD_PUT, NEWLINE_CHAR, 11'd0);
    send_item(CMD_PUT, 8'h7E, 11'd0);
    send_item(CMD_PUT, SPACE_CHAR, 11'd0);
    send_item(CMD_PUT, NEWLINE_CHAR, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd80);
    send_item(CMD_READ, 8'h00, 11'd81);
    send_item(CMD_READ, 8'h00, 11'd160);
    wait_results_drained();

    run_random_bursts(200);
    wait_results_drained();

    send_idle_pct = 57;
    recv_idle_pct = 21;
    run_random_bursts(200);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_bursts(200);
    wait_results_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (screen_board.failures == 0 && screen_board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
